[hdl/stg_pkg.sv]
// Package with shared constants, types and the quarter-wave sine table of the tone generator.
package stg_pkg;

  localparam int PHASE_BITS   = 32;
  localparam int TABLE_BITS   = 12;
  localparam int COUNT_BITS   = 24;
  localparam int STEP_BITS    = 32;
  localparam int TOTAL_BITS   = 24;
  localparam int MAG_BITS     = 14;
  localparam int SAMPLE_BITS  = 15;
  localparam int QUARTER_BITS = TABLE_BITS - 2;
  localparam int QUARTER      = 1 << QUARTER_BITS;

  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  localparam logic [STEP_BITS-1:0]  PHASE_STEP_RESET   = STEP_BITS'(42852282);
  localparam logic [TOTAL_BITS-1:0] SAMPLE_TOTAL_RESET = TOTAL_BITS'(44100);

  // Peak of the quarter wave: 16383.5 truncates to 16383.
  localparam logic [MAG_BITS-1:0] MAG_PEAK = MAG_BITS'(16383);

  localparam logic [63:0] HALF_PI_Q62  = 64'h6487ED5110B4611A;
  localparam logic [63:0] AMPLITUDE    = 64'd32767;
  localparam int          TAYLOR_TERMS = 12;

  // Ceiling reciprocals of the series denominators (2k)*(2k+1), scaled by 2^RECIP_SHIFT. Every
  // divisor is below 2^(RECIP_SHIFT-64), so the shifted product is the exact floor quotient
  // for any 64-bit dividend.
  localparam int          RECIP_SHIFT = 74;
  localparam logic [79:0] RECIP_ONE   = 80'd1 << RECIP_SHIFT;

  typedef logic [79:0] taylor_recip_t [TAYLOR_TERMS];

  localparam taylor_recip_t TAYLOR_RECIP = '{
    (RECIP_ONE + 80'd5)   / 80'd6,
    (RECIP_ONE + 80'd19)  / 80'd20,
    (RECIP_ONE + 80'd41)  / 80'd42,
    (RECIP_ONE + 80'd71)  / 80'd72,
    (RECIP_ONE + 80'd109) / 80'd110,
    (RECIP_ONE + 80'd155) / 80'd156,
    (RECIP_ONE + 80'd209) / 80'd210,
    (RECIP_ONE + 80'd271) / 80'd272,
    (RECIP_ONE + 80'd341) / 80'd342,
    (RECIP_ONE + 80'd419) / 80'd420,
    (RECIP_ONE + 80'd505) / 80'd506,
    (RECIP_ONE + 80'd599) / 80'd600
  };

  typedef enum logic {
    REG_PHASE_STEP   = 1'b0,
    REG_SAMPLE_TOTAL = 1'b1
  } reg_index_e;

  typedef logic [MAG_BITS-1:0] qsin_rom_t [QUARTER];

  // Unsigned Q2.62 product.
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // Builds trunc(16383.5 * sin(pi/2 * q / QUARTER)) for q below QUARTER at elaboration.
  // The sine is a Taylor series up to x^25 in Q2.62.
  function automatic qsin_rom_t build_qsin_rom();
    qsin_rom_t    rom;
    logic [63:0]  frac;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [159:0] quot;
    logic [127:0] scaled;
    for (int q = 0; q < QUARTER; q++) begin
      frac = 64'(q) << (62 - QUARTER_BITS);
      x    = mul_q62(HALF_PI_Q62, frac);
      x2   = mul_q62(x, x);
      term = x;
      sum  = x;
      for (int k = 1; k <= TAYLOR_TERMS; k++) begin
        term = mul_q62(term, x2);
        quot = {96'd0, term} * {80'd0, TAYLOR_RECIP[k-1]};
        term = quot[RECIP_SHIFT +: 64];
        if (k[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      scaled = {64'd0, sum} * {64'd0, AMPLITUDE};
      rom[q] = scaled[63+MAG_BITS-1:63];
    end
    return rom;
  endfunction

  localparam qsin_rom_t QSIN_ROM = build_qsin_rom();

endpackage

[hdl/stg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module stg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hdl/stg_sine_lut.sv]
// Quarter-wave sine lookup: folds a table phase, reads the magnitude RAM, restores the sign.
module stg_sine_lut
  import stg_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [TABLE_BITS-1:0]         phase_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  output logic                          busy_o
);

  logic                    fill_busy_q, fill_busy_d;
  logic [QUARTER_BITS-1:0] fill_addr_q, fill_addr_d;

  logic                    neg;
  logic [TABLE_BITS-2:0]   half_phase;
  logic [TABLE_BITS-2:0]   folded;
  logic                    neg_q;
  logic                    peak_q;
  logic [MAG_BITS-1:0]     rom_data;
  logic [MAG_BITS-1:0]     mag;
  logic [SAMPLE_BITS-1:0]  mag_ext;

  // The magnitude RAM is loaded from the constant table once after reset.
  always_comb begin
    fill_busy_d = fill_busy_q;
    fill_addr_d = fill_addr_q;
    if (fill_busy_q) begin
      fill_addr_d = fill_addr_q + 1'b1;
      if (&fill_addr_q) begin
        fill_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_busy_q <= 1'b1;
      fill_addr_q <= '0;
    end else begin
      fill_busy_q <= fill_busy_d;
      fill_addr_q <= fill_addr_d;
    end
  end

  // The second half wave is the first one negated; the second quarter mirrors the first.
  assign neg        = phase_i[TABLE_BITS-1];
  assign half_phase = phase_i[TABLE_BITS-2:0];
  assign folded     = (half_phase <= (TABLE_BITS-1)'(QUARTER))
                      ? half_phase
                      : (TABLE_BITS-1)'(2 * QUARTER) - half_phase;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      neg_q  <= neg;
      peak_q <= folded[QUARTER_BITS];
    end
  end

  stg_ram #(
    .WIDTH(MAG_BITS),
    .DEPTH(QUARTER)
  ) u_mag_ram (
    .clk_i    (clk_i),
    .wr_en_i  (fill_busy_q),
    .wr_addr_i(fill_addr_q),
    .wr_data_i(QSIN_ROM[fill_addr_q]),
    .rd_en_i  (rd_en_i),
    .rd_addr_i(folded[QUARTER_BITS-1:0]),
    .rd_data_o(rom_data)
  );

  assign mag      = peak_q ? MAG_PEAK : rom_data;
  assign mag_ext  = {1'b0, mag};
  assign sample_o = neg_q ? -mag_ext : mag_ext;
  assign busy_o   = fill_busy_q;

endmodule

[hdl/sine_tone_generator_unit.sv]
// Top level of the direct digital synthesis sine tone generator.
//
// Each input transaction is one sample tick and yields exactly one output transaction carrying
// a 15-bit signed sample and a last flag. A 32-bit phase accumulator advances by phase_step
// after every sample; its top 12 bits select trunc(16383.5 * sin(2*pi*p/4096)) from a
// 1024-entry quarter-wave magnitude RAM, with mirroring and sign restored around it. A sample
// counter flags the final sample of a tone of sample_total samples (a total of zero acts as
// one) and then clears phase and count; restart_i clears them before its own sample. The block
// takes one transaction per clock cycle while it does not stall; a result passes through the
// registered RAM read and then the output register. After reset the magnitude RAM is loaded
// from a constant table, during which in_stall_o is high; the APB port works throughout.
// Registers: phase_step at byte address 0 (reset 42852282) and sample_total at byte address 4
// (reset 44100). Write them only while no transaction is in flight.
module sine_tone_generator_unit
  import stg_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_ADDR_BITS-1:0]      paddr,
  input  logic [APB_DATA_BITS-1:0]      pwdata,
  output logic [APB_DATA_BITS-1:0]      prdata,
  output logic                          pready,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          restart_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  output logic                          last_o
);

  logic [STEP_BITS-1:0]  phase_step_q;
  logic [TOTAL_BITS-1:0] sample_total_q;
  logic                  cfg_write;
  reg_index_e            cfg_index;

  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [COUNT_BITS-1:0] index_q, index_d;
  logic [PHASE_BITS-1:0] cur_phase;
  logic [COUNT_BITS-1:0] cur_index;
  logic [COUNT_BITS:0]   next_count;
  logic                  tone_last;

  logic                  advance;
  logic                  accept;
  logic                  lut_busy;
  logic signed [SAMPLE_BITS-1:0] lut_sample;

  logic                  s1_valid_q;
  logic                  s1_last_q;
  logic                  out_valid_q;
  logic                  out_last_q;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;

  // Configuration registers. The register index is the word address.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign cfg_index = reg_index_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q   <= PHASE_STEP_RESET;
      sample_total_q <= SAMPLE_TOTAL_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PHASE_STEP:   phase_step_q   <= pwdata[STEP_BITS-1:0];
        REG_SAMPLE_TOTAL: sample_total_q <= pwdata[TOTAL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_PHASE_STEP:   prdata = APB_DATA_BITS'(phase_step_q);
      REG_SAMPLE_TOTAL: prdata = APB_DATA_BITS'(sample_total_q);
      default:          prdata = '0;
    endcase
  end

  // The pipeline moves whenever the output register is empty or being drained.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = lut_busy || !advance;
  assign accept     = in_valid_i && !in_stall_o;

  // Restart clears phase and count before this tick's sample is formed.
  assign cur_phase  = restart_i ? '0 : phase_q;
  assign cur_index  = restart_i ? '0 : index_q;
  assign next_count = {1'b0, cur_index} + 1'b1;

  // A total of zero behaves like one, and a full counter ends the tone instead of wrapping.
  assign tone_last = (next_count >= (COUNT_BITS+1)'(sample_total_q)) || (&cur_index);

  always_comb begin
    phase_d = phase_q;
    index_d = index_q;
    if (accept) begin
      if (tone_last) begin
        phase_d = '0;
        index_d = '0;
      end else begin
        phase_d = cur_phase + PHASE_BITS'(phase_step_q);
        index_d = next_count[COUNT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      index_q <= '0;
    end else begin
      phase_q <= phase_d;
      index_q <= index_d;
    end
  end

  stg_sine_lut u_sine_lut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (advance),
    .phase_i (cur_phase[PHASE_BITS-1 -: TABLE_BITS]),
    .sample_o(lut_sample),
    .busy_o  (lut_busy)
  );

  // Stage one waits for the RAM read; the output register then holds the finished result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= accept;
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_last_q    <= tone_last;
      out_last_q   <= s1_last_q;
      out_sample_q <= lut_sample;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = out_sample_q;
  assign last_o      = out_last_q;

  // Nothing enters the pipeline while the magnitude RAM is still being loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni) lut_busy |-> !s1_valid_q && !out_valid_q)
    else $error("transaction in flight during RAM load");

  // The last sample of a tone leaves phase and count cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && tone_last |=> phase_q == '0 && index_q == '0)
    else $error("tone state not cleared after last sample");

  // Inside a tone the count steps by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !restart_i && !tone_last |=> index_q == $past(index_q) + 1'b1)
    else $error("sample count did not step by one");

  // A result becomes valid only behind an occupied first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("output valid without a transaction in stage one");

endmodule

[test/testbench.sv]
// Self-checking testbench for the sine tone generator, with its own bit-exact sample predictor.
`timescale 1ns / 100ps

module testbench
  import stg_pkg::*;
();

  // The tone is a sequence of samples, one per input transaction. The predictor keeps its own
  // phase accumulator and sample count. It forms each sample from a quarter-wave magnitude
  // table that it builds itself with integer arithmetic, so the expected values are exact
  // down to the last bit.

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;
  } tone_sample_t;

  localparam int unsigned QUARTER_TURN = 1 << (TABLE_BITS - 2);

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     psel        = 1'b0;
  logic                     penable     = 1'b0;
  logic                     pwrite      = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr       = '0;
  logic [APB_DATA_BITS-1:0] pwdata      = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic                     restart_i   = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample_o;
  logic                     last_o;

  sine_tone_generator_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .restart_i  (restart_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sample_o   (sample_o),
    .last_o     (last_o)
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the block's configuration and state.
  logic [STEP_BITS-1:0]  tone_step  = PHASE_STEP_RESET;
  logic [TOTAL_BITS-1:0] tone_total = SAMPLE_TOTAL_RESET;
  logic [PHASE_BITS-1:0] tone_phase = '0;
  logic [COUNT_BITS-1:0] tone_count = '0;

  // Magnitudes for every quarter-wave position, both ends included.
  logic [MAG_BITS-1:0] sine_mag [0:QUARTER_TURN];

  tone_sample_t pending_samples[$];

  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;

  int unsigned mismatch_count  = 0;
  int unsigned ticks_accepted  = 0;
  int unsigned samples_checked = 0;
  int unsigned tone_ends_seen  = 0;
  int unsigned reg_writes      = 0;

  // Unsigned Q2.62 fixed-point product, truncated.
  function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] wide;
    wide = 128'(a) * 128'(b);
    return 64'(wide >> 62);
  endfunction

  // The magnitude table: the angle (pi/2)*q/QUARTER_TURN goes through a Taylor series up to
  // the x^25 term in Q2.62, and the sum is scaled by 32767/2 with truncation.
  initial begin
    logic [63:0]  angle;
    logic [63:0]  angle_sq;
    logic [63:0]  term;
    logic [63:0]  series;
    logic [127:0] scaled;
    for (int unsigned q = 0; q <= QUARTER_TURN; q++) begin
      angle    = q62_product(64'h6487ED5110B4611A, 64'(q) << (64 - TABLE_BITS));
      angle_sq = q62_product(angle, angle);
      term     = angle;
      series   = angle;
      for (int unsigned k = 1; k <= 12; k++) begin
        term = q62_product(term, angle_sq) / 64'((2 * k) * (2 * k + 1));
        series = (k % 2 == 1) ? series - term : series + term;
      end
      scaled = 128'(series) * 128'd32767;
      sine_mag[q] = MAG_BITS'(scaled >> 63);
    end
  end

  // Works out the sample of one tick and advances the shadow state.
  function automatic tone_sample_t predict_tick(input logic restart);
    tone_sample_t            result;
    logic [TABLE_BITS-1:0]   index;
    logic [TABLE_BITS-2:0]   half_index;
    int unsigned             q;
    logic [SAMPLE_BITS-1:0]  magnitude;
    if (restart) begin
      tone_phase = '0;
      tone_count = '0;
    end
    index      = tone_phase[PHASE_BITS-1 -: TABLE_BITS];
    half_index = index[TABLE_BITS-2:0];
    q = (half_index <= QUARTER_TURN) ? half_index : 2 * QUARTER_TURN - half_index;
    magnitude = SAMPLE_BITS'(sine_mag[q]);
    result.sample = index[TABLE_BITS-1] ? SAMPLE_BITS'(0) - magnitude : magnitude;
    // A total of zero acts as one; a full counter ends the tone as well.
    result.last = ({1'b0, tone_count} + 1'b1 >= {1'b0, tone_total}) || (&tone_count);
    if (result.last) begin
      tone_phase = '0;
      tone_count = '0;
    end else begin
      tone_phase = tone_phase + tone_step;
      tone_count = tone_count + 1'b1;
    end
    return result;
  endfunction

  // Both channels are observed at the rising edge. Each accepted tick is predicted at once,
  // and each accepted sample is checked against the oldest prediction still waiting.
  always @(posedge clk_i) begin
    tone_sample_t expected;
    tone_sample_t predicted;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predicted = predict_tick(restart_i);
      pending_samples = {pending_samples, predicted};
      ticks_accepted++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected sample %0d last %0b", $time, sample_o, last_o);
        mismatch_count++;
      end else begin
        expected = pending_samples.pop_front();
        samples_checked++;
        if (last_o) begin
          tone_ends_seen++;
        end
        if (sample_o !== expected.sample) begin
          $display("%0t: sample mismatch, expected %0d, actual %0d", $time,
                   $signed(expected.sample), sample_o);
          mismatch_count++;
        end
        if (last_o !== expected.last) begin
          $display("%0t: last flag mismatch, expected %0b, actual %0b", $time,
                   expected.last, last_o);
          mismatch_count++;
        end
      end
    end
  end

  // The receiver stalls at random, at the rate that the current test sets.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Every task below starts and ends at a falling edge at which nothing has been driven yet.

  task automatic read_reg(input reg_index_e which, output logic [APB_DATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= APB_ADDR_BITS'(4 * int'(which));
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic check_reg(input reg_index_e which, input logic [APB_DATA_BITS-1:0] expected);
    logic [APB_DATA_BITS-1:0] actual;
    read_reg(which, actual);
    if (actual !== expected) begin
      $display("%0t: register %s reads back wrong, expected %0h, actual %0h", $time,
               which.name(), expected, actual);
      mismatch_count++;
    end
  endtask

  // Writes a register, mirrors it into the shadow configuration, and reads it back.
  task automatic write_reg(input reg_index_e which, input logic [APB_DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_BITS'(4 * int'(which));
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (which == REG_PHASE_STEP) begin
      tone_step = STEP_BITS'(value);
    end else begin
      tone_total = TOTAL_BITS'(value);
    end
    reg_writes++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    check_reg(which, which == REG_PHASE_STEP ? APB_DATA_BITS'(tone_step)
                                             : APB_DATA_BITS'(tone_total));
  endtask

  task automatic set_tone(input logic [STEP_BITS-1:0] step, input logic [TOTAL_BITS-1:0] total);
    write_reg(REG_PHASE_STEP, APB_DATA_BITS'(step));
    write_reg(REG_SAMPLE_TOTAL, APB_DATA_BITS'(total));
  endtask

  // Offers one tick, after a random gap, and holds it until the block takes the transaction.
  // Valid stays high into the next call, which keeps it up for back-to-back ticks.
  task automatic send_tick(input logic restart);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      restart_i  <= 1'($urandom_range(1));
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Holds the sender back until every predicted sample has come out. Each tick yields one
  // sample, so a short pause is enough afterwards.
  task automatic drain_samples();
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic reset_dut();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
  endtask

  // Reset values of both registers, and a few samples of the default tone. The first tick
  // waits out the table load that follows reset.
  task automatic test_reset_defaults();
    check_reg(REG_PHASE_STEP, APB_DATA_BITS'(PHASE_STEP_RESET));
    check_reg(REG_SAMPLE_TOTAL, APB_DATA_BITS'(SAMPLE_TOTAL_RESET));
    repeat (4) send_tick(1'b0);
    drain_samples();
  endtask

  // A quarter-turn step lands on zero, the positive peak, sin(pi) and the negative peak.
  task automatic test_quarter_points();
    set_tone(32'h4000_0000, 24'd100);
    repeat (5) send_tick(1'b0);
    drain_samples();
  endtask

  // The largest step wraps the phase on every tick, and a zero step holds it.
  task automatic test_step_extremes();
    set_tone(32'hFFFF_FFFF, 24'hFF_FFFF);
    repeat (3) send_tick(1'b0);
    drain_samples();
    set_tone(32'h0000_0000, 24'd50);
    repeat (2) send_tick(1'b0);
    drain_samples();
  endtask

  // Tone lengths of zero and one mark every sample as last. A length lowered below the count
  // already reached ends the tone on the next sample.
  task automatic test_tone_length();
    set_tone(32'h0123_4567, 24'd0);
    repeat (2) send_tick(1'b0);
    drain_samples();
    write_reg(REG_SAMPLE_TOTAL, 32'd1);
    repeat (2) send_tick(1'b0);
    drain_samples();
    write_reg(REG_SAMPLE_TOTAL, 32'd1000);
    repeat (4) send_tick(1'b0);
    drain_samples();
    write_reg(REG_SAMPLE_TOTAL, 32'd2);
    send_tick(1'b0);
    drain_samples();
  endtask

  // A restart clears phase and count before its own sample.
  task automatic test_restart();
    set_tone(32'h1000_0000, 24'd8);
    repeat (3) send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    drain_samples();
  endtask

  // Random tones under one idling pattern. The ticks come in blocks, each with a fresh tone
  // setting written once the previous block has fully drained. Most tones are short, so that
  // tone ends are frequent; some use the extreme lengths and steps.
  task automatic test_random_tones(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input int unsigned ticks);
    logic [STEP_BITS-1:0]  step;
    logic [TOTAL_BITS-1:0] total;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int block = 0; block < 5; block++) begin
      case ($urandom_range(7))
        0:       step = '0;
        1:       step = '1;
        2:       step = STEP_BITS'($urandom_range(1, 65535));
        default: step = STEP_BITS'($urandom);
      endcase
      case ($urandom_range(9))
        0:       total = '0;
        1:       total = '1;
        2:       total = TOTAL_BITS'($urandom);
        3:       total = TOTAL_BITS'($urandom_range(65, 600));
        default: total = TOTAL_BITS'($urandom_range(1, 64));
      endcase
      set_tone(step, total);
      for (int unsigned n = 0; n < ticks / 5; n++) begin
        send_tick($urandom_range(99) < 3);
      end
      drain_samples();
    end
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
  endtask

  // Waits out the last samples with a cycle limit, then reports the verdict.
  task automatic finish_run();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0 && waited < 10000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    $display("Covered %0d ticks and %0d checked samples, %0d of them tone ends,",
             ticks_accepted, samples_checked, tone_ends_seen);
    $display("under %0d register writes, with restarts and four idling patterns.", reg_writes);
    if (mismatch_count == 0 && pending_samples.size() == 0) begin
      $display("** sine_tone_generator_unit: PASSED **");
    end else begin
      $display("** sine_tone_generator_unit: FAILED **");
    end
    $finish;
  endtask

  initial begin
    reset_dut();
    test_reset_defaults();
    test_quarter_points();
    test_step_extremes();
    test_tone_length();
    test_restart();
    test_random_tones(0, 0, 500);
    test_random_tones(65, 0, 500);
    test_random_tones(0, 65, 500);
    test_random_tones(22, 22, 500);
    finish_run();
  end

  // Safety net: the run is far shorter than this even with every stall at its worst.
  initial begin
    #2000000;
    $display("** sine_tone_generator_unit: FAILED **");
    $finish;
  end

endmodule

[filelist.f]
hdl/stg_pkg.sv
hdl/stg_ram.sv
hdl/stg_sine_lut.sv
hdl/sine_tone_generator_unit.sv
test/testbench.sv
